// File: rtl/alp_pkg.sv
// Alarm LED pattern controller: shared types and constants.
// Used by alp_cfg, alp_core and alarm_led_pattern_controller; no dependencies.
package alp_pkg;

  localparam int MsW   = 32;  // millisecond time base width
  localparam int CfgW  = 16;  // timing register width
  localparam int RegIdxW = 3; // configuration register index width

  // Status and mode codes
  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_ALARM = 3'd1;
  localparam logic [2:0] MODE_CONN  = 3'd2;
  localparam logic [2:0] MODE_LOSS1 = 3'd3;
  localparam logic [2:0] MODE_LOSS2 = 3'd4;
  localparam logic [2:0] MODE_LOSS3 = 3'd5;

  // Status sources
  localparam logic [1:0] SRC_ALARM = 2'd0;
  localparam logic [1:0] SRC_CONN  = 2'd1;
  localparam logic [1:0] SRC_LOSS  = 2'd2;

  // Actions
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_SET  = 1'b1;

  // Pulse sequencer steps
  localparam logic [1:0] STEP_START = 2'd0;
  localparam logic [1:0] STEP_ON    = 2'd1;
  localparam logic [1:0] STEP_GAP   = 2'd2;
  localparam logic [1:0] STEP_PAUSE = 2'd3;

  // Configuration register indexes
  localparam logic [RegIdxW-1:0] REG_ALARM_ON  = 3'd0;
  localparam logic [RegIdxW-1:0] REG_ALARM_OFF = 3'd1;
  localparam logic [RegIdxW-1:0] REG_CONN_ON   = 3'd2;
  localparam logic [RegIdxW-1:0] REG_CONN_OFF  = 3'd3;
  localparam logic [RegIdxW-1:0] REG_PULSE_ON  = 3'd4;
  localparam logic [RegIdxW-1:0] REG_PULSE_GAP = 3'd5;
  localparam logic [RegIdxW-1:0] REG_PAUSE     = 3'd6;

  // Reset values of the timing registers
  localparam logic [CfgW-1:0] RST_ALARM_ON  = 16'd200;
  localparam logic [CfgW-1:0] RST_ALARM_OFF = 16'd400;
  localparam logic [CfgW-1:0] RST_CONN_ON   = 16'd1000;
  localparam logic [CfgW-1:0] RST_CONN_OFF  = 16'd0;
  localparam logic [CfgW-1:0] RST_PULSE_ON  = 16'd10;
  localparam logic [CfgW-1:0] RST_PULSE_GAP = 16'd350;
  localparam logic [CfgW-1:0] RST_PAUSE     = 16'd1500;

  typedef struct packed {
    logic [CfgW-1:0] alarm_on_ms;
    logic [CfgW-1:0] alarm_off_ms;
    logic [CfgW-1:0] conn_on_ms;
    logic [CfgW-1:0] conn_off_ms;
    logic [CfgW-1:0] pulse_on_ms;
    logic [CfgW-1:0] pulse_gap_ms;
    logic [CfgW-1:0] pause_ms;
  } cfg_t;

endpackage

// File: rtl/alarm_led_pattern_controller.sv
// Alarm LED pattern controller, top level: input register, update core, result register.
// Depends on alp_pkg, alp_cfg and alp_core.
//
// Each accepted item (a millisecond tick or a source status write) produces one
// result: the LED drive and the display mode after that item. Throughput is one
// item per clock while the output is not stalled; an item passes through the input
// register, then through the state update into the result register. The input
// register takes a new item while a result still waits at the output, as long as
// it is empty itself. Timing registers are written through the cfg port, which is
// always ready; indexes past six are dropped.
module alarm_led_pattern_controller import alp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // Configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [RegIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  // Input items
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic [1:0]         source,
  input  logic [2:0]         status,
  // Result items
  output logic               out_valid,
  input  logic               out_ready,
  output logic               led_on,
  output logic [2:0]         mode
);

  cfg_t       cfg;
  logic       hold_valid;
  logic       hold_action;
  logic [1:0] hold_source;
  logic [2:0] hold_status;
  logic       step;
  logic       led_next;
  logic [2:0] mode_next;

  assign cfg_ready = 1'b1;

  alp_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Item in the input register moves on when the result slot is free
  assign step     = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || step;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_action <= action;
      hold_source <= source;
      hold_status <= status;
    end
  end

  alp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .action    (hold_action),
    .source    (hold_source),
    .status    (hold_status),
    .cfg       (cfg),
    .led_next  (led_next),
    .mode_next (mode_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      led_on <= led_next;
      mode   <= mode_next;
    end
  end

endmodule

// File: rtl/alp_cfg.sv
// Timing register file of the alarm LED pattern controller.
// Depends on alp_pkg.
module alp_cfg import alp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [RegIdxW-1:0] wr_index,
  input  logic [CfgW-1:0]    wr_data,
  output cfg_t               cfg
);

  cfg_t regs;

  // Register writes; indexes past the last register are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.alarm_on_ms  <= RST_ALARM_ON;
      regs.alarm_off_ms <= RST_ALARM_OFF;
      regs.conn_on_ms   <= RST_CONN_ON;
      regs.conn_off_ms  <= RST_CONN_OFF;
      regs.pulse_on_ms  <= RST_PULSE_ON;
      regs.pulse_gap_ms <= RST_PULSE_GAP;
      regs.pause_ms     <= RST_PAUSE;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ALARM_ON:  regs.alarm_on_ms  <= wr_data;
        REG_ALARM_OFF: regs.alarm_off_ms <= wr_data;
        REG_CONN_ON:   regs.conn_on_ms   <= wr_data;
        REG_CONN_OFF:  regs.conn_off_ms  <= wr_data;
        REG_PULSE_ON:  regs.pulse_on_ms  <= wr_data;
        REG_PULSE_GAP: regs.pulse_gap_ms <= wr_data;
        REG_PAUSE:     regs.pause_ms     <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

// File: rtl/alp_core.sv
// Status, mode and LED pattern state with its single-pass update logic.
// Depends on alp_pkg.
module alp_core import alp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic       action,
  input  logic [1:0] source,
  input  logic [2:0] status,
  input  cfg_t       cfg,
  output logic       led_next,
  output logic [2:0] mode_next
);

  logic [MsW-1:0] now_ms, switch_mark, pulse_mark;
  logic           led_lit;
  logic [2:0]     current_mode;
  logic [2:0]     src_alarm, src_conn, src_loss;
  logic [1:0]     pulse_step, pulse_count;

  logic [MsW-1:0] now_ms_next, switch_mark_next, pulse_mark_next;
  logic [2:0]     src_alarm_next, src_conn_next, src_loss_next;
  logic [1:0]     pulse_step_next, pulse_count_next;

  logic [MsW-1:0] tick_ms, blink_held, pulse_held;
  logic [CfgW-1:0] on_time, off_time;
  logic [1:0]     pulses, count_inc;

  assign tick_ms    = now_ms + 1'b1;
  assign blink_held = tick_ms - switch_mark;
  assign pulse_held = tick_ms - pulse_mark;
  assign count_inc  = pulse_count + 1'b1;
  // Loss modes one to three pulses map onto counts one to three
  assign pulses     = 2'(current_mode - MODE_CONN);
  assign on_time    = (current_mode == MODE_ALARM) ? cfg.alarm_on_ms  : cfg.conn_on_ms;
  assign off_time   = (current_mode == MODE_ALARM) ? cfg.alarm_off_ms : cfg.conn_off_ms;

  // Next state for one item
  always_comb begin
    now_ms_next      = now_ms;
    switch_mark_next = switch_mark;
    pulse_mark_next  = pulse_mark;
    led_next         = led_lit;
    mode_next        = current_mode;
    src_alarm_next   = src_alarm;
    src_conn_next    = src_conn;
    src_loss_next    = src_loss;
    pulse_step_next  = pulse_step;
    pulse_count_next = pulse_count;

    if (action == ACT_SET) begin
      case (source)
        SRC_ALARM: src_alarm_next = status;
        SRC_CONN:  src_conn_next  = status;
        SRC_LOSS:  src_loss_next  = status;
        default: ;
      endcase
      // Connection wins over alarm, alarm over link loss
      if (src_conn_next != MODE_IDLE) begin
        mode_next = MODE_CONN;
      end else if (src_alarm_next != MODE_IDLE) begin
        mode_next = MODE_ALARM;
      end else if (src_loss_next != MODE_IDLE) begin
        mode_next = src_loss_next;
      end else begin
        led_next         = 1'b0;
        switch_mark_next = now_ms;
        mode_next        = MODE_IDLE;
      end
    end else begin
      now_ms_next = tick_ms;
      case (current_mode)
        MODE_IDLE: begin
          led_next         = 1'b0;
          switch_mark_next = tick_ms;
        end
        MODE_ALARM, MODE_CONN: begin
          if (led_lit) begin
            if (blink_held >= MsW'(on_time)) begin
              led_next         = 1'b0;
              switch_mark_next = tick_ms;
            end
          end else if (blink_held >= MsW'(off_time)) begin
            led_next         = 1'b1;
            switch_mark_next = tick_ms;
          end
        end
        MODE_LOSS1, MODE_LOSS2, MODE_LOSS3: begin
          case (pulse_step)
            STEP_START: begin
              pulse_mark_next  = tick_ms;
              led_next         = 1'b1;
              switch_mark_next = tick_ms;
              pulse_step_next  = STEP_ON;
            end
            STEP_ON: begin
              if (pulse_held > MsW'(cfg.pulse_on_ms)) begin
                pulse_mark_next  = tick_ms;
                pulse_step_next  = STEP_GAP;
                led_next         = 1'b0;
                switch_mark_next = tick_ms;
              end
            end
            STEP_GAP: begin
              if (pulse_held > MsW'(cfg.pulse_gap_ms)) begin
                pulse_mark_next  = tick_ms;
                pulse_count_next = count_inc;
                pulse_step_next  = (count_inc >= pulses) ? STEP_PAUSE : STEP_START;
              end
            end
            default: begin
              if (pulse_held > MsW'(cfg.pause_ms)) begin
                pulse_count_next = 2'd0;
                pulse_step_next  = STEP_START;
              end
            end
          endcase
        end
        default: ;  // unknown mode: only time advances
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms       <= '0;
      switch_mark  <= '0;
      pulse_mark   <= '0;
      led_lit      <= 1'b0;
      current_mode <= MODE_IDLE;
      src_alarm    <= MODE_IDLE;
      src_conn     <= MODE_IDLE;
      src_loss     <= MODE_IDLE;
      pulse_step   <= STEP_START;
      pulse_count  <= 2'd0;
    end else if (step) begin
      now_ms       <= now_ms_next;
      switch_mark  <= switch_mark_next;
      pulse_mark   <= pulse_mark_next;
      led_lit      <= led_next;
      current_mode <= mode_next;
      src_alarm    <= src_alarm_next;
      src_conn     <= src_conn_next;
      src_loss     <= src_loss_next;
      pulse_step   <= pulse_step_next;
      pulse_count  <= pulse_count_next;
    end
  end

endmodule

// File: bench/alp_checker.sv
`timescale 1ns / 100ps
// Checker for the alarm LED pattern controller: watches the config, input and result channels,
// predicts LED drive and display mode per item, and counts mismatches. Depends on alp_pkg.
module alp_checker import alp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [RegIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               action,
  input  logic [1:0]         source,
  input  logic [2:0]         status,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               led_on,
  input  logic [2:0]         mode,
  output int                 error_count,
  output int                 in_flight
);

  typedef struct packed {
    logic       lit;
    logic [2:0] mode;
  } led_state_t;

  // Predicted controller state
  cfg_t            timing;
  logic [MsW-1:0]  ms_now;
  logic [MsW-1:0]  switch_at;
  logic [MsW-1:0]  pulse_since;
  logic            lit;
  logic [2:0]      disp_mode;
  logic [2:0]      src_stat [3];
  logic [1:0]      p_step;
  logic [1:0]      p_count;

  led_state_t led_expect_q [$];

  function automatic void drive_led(input logic on);
    lit       = on;
    switch_at = ms_now;
  endfunction

  // Blink with minimum on/off hold times
  function automatic void blink(input logic [CfgW-1:0] on_t, input logic [CfgW-1:0] off_t);
    logic [MsW-1:0] held;
    held = ms_now - switch_at;
    if (lit) begin
      if (held >= on_t) drive_led(1'b0);
    end else begin
      if (held >= off_t) drive_led(1'b1);
    end
  endfunction

  // Link-loss burst: short pulses, gaps, then a long pause; strict compares
  function automatic void pulse_burst(input logic [1:0] pulses);
    logic [MsW-1:0] held;
    held = ms_now - pulse_since;
    case (p_step)
      STEP_START: begin
        pulse_since = ms_now;
        drive_led(1'b1);
        p_step = STEP_ON;
      end
      STEP_ON: begin
        if (held > timing.pulse_on_ms) begin
          pulse_since = ms_now;
          p_step = STEP_GAP;
          drive_led(1'b0);
        end
      end
      STEP_GAP: begin
        if (held > timing.pulse_gap_ms) begin
          pulse_since = ms_now;
          p_count = p_count + 2'd1;
          p_step = (p_count >= pulses) ? STEP_PAUSE : STEP_START;
        end
      end
      default: begin
        if (held > timing.pause_ms) begin
          p_count = '0;
          p_step = STEP_START;
        end
      end
    endcase
  endfunction

  function automatic void reset_display();
    timing.alarm_on_ms  = RST_ALARM_ON;
    timing.alarm_off_ms = RST_ALARM_OFF;
    timing.conn_on_ms   = RST_CONN_ON;
    timing.conn_off_ms  = RST_CONN_OFF;
    timing.pulse_on_ms  = RST_PULSE_ON;
    timing.pulse_gap_ms = RST_PULSE_GAP;
    timing.pause_ms     = RST_PAUSE;
    ms_now      = '0;
    switch_at   = '0;
    pulse_since = '0;
    lit         = 1'b0;
    disp_mode   = MODE_IDLE;
    for (int i = 0; i < 3; i++) src_stat[i] = MODE_IDLE;
    p_step  = STEP_START;
    p_count = '0;
  endfunction

  // One input item: status write or millisecond tick; returns LED and mode after it
  function automatic led_state_t predict_display(input logic act, input logic [1:0] src,
                                                 input logic [2:0] st);
    led_state_t r;
    if (act == ACT_SET) begin
      if (src <= SRC_LOSS) src_stat[src] = st;
      if (src_stat[SRC_CONN] != MODE_IDLE) disp_mode = MODE_CONN;
      else if (src_stat[SRC_ALARM] != MODE_IDLE) disp_mode = MODE_ALARM;
      else if (src_stat[SRC_LOSS] != MODE_IDLE) disp_mode = src_stat[SRC_LOSS];
      else begin
        drive_led(1'b0);
        disp_mode = MODE_IDLE;
      end
    end else begin
      ms_now = ms_now + 1;
      case (disp_mode)
        MODE_IDLE:  drive_led(1'b0);
        MODE_ALARM: blink(timing.alarm_on_ms, timing.alarm_off_ms);
        MODE_CONN:  blink(timing.conn_on_ms, timing.conn_off_ms);
        MODE_LOSS1: pulse_burst(2'd1);
        MODE_LOSS2: pulse_burst(2'd2);
        MODE_LOSS3: pulse_burst(2'd3);
        default: ;  // reserved codes: time advances, LED holds
      endcase
    end
    r.lit  = lit;
    r.mode = disp_mode;
    return r;
  endfunction

  // Sample all channels at the rising edge
  always @(posedge clk) begin : watch
    led_state_t want;
    if (rst) begin
      reset_display();
      led_expect_q.delete();
      error_count = 0;
      in_flight   = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ALARM_ON:  timing.alarm_on_ms  = cfg_data;
          REG_ALARM_OFF: timing.alarm_off_ms = cfg_data;
          REG_CONN_ON:   timing.conn_on_ms   = cfg_data;
          REG_CONN_OFF:  timing.conn_off_ms  = cfg_data;
          REG_PULSE_ON:  timing.pulse_on_ms  = cfg_data;
          REG_PULSE_GAP: timing.pulse_gap_ms = cfg_data;
          REG_PAUSE:     timing.pause_ms     = cfg_data;
          default: ;
        endcase
      end
      // Result side first: a result always belongs to an earlier item
      if (out_valid && out_ready) begin
        if (led_expect_q.size() == 0) begin
          if (error_count < 10)
            $display("%0t: unexpected result led_on=%0b mode=%0d", $realtime, led_on, mode);
          error_count++;
        end else begin
          want = led_expect_q.pop_front();
          if (led_on !== want.lit || mode !== want.mode) begin
            if (error_count < 10)
              $display("%0t: mismatch led_on exp %0b got %0b, mode exp %0d got %0d",
                       $realtime, want.lit, led_on, want.mode, mode);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready)
        led_expect_q.push_back(predict_display(action, source, status));
      in_flight = led_expect_q.size();
    end
  end

endmodule

// File: bench/tb_alarm_led_pattern_controller.sv
`timescale 1ns / 100ps
// Testbench top for the alarm LED pattern controller: clock, reset, stimulus and verdict.
// Depends on alp_pkg, alp_checker and the controller RTL.
module tb_alarm_led_pattern_controller;
  import alp_pkg::*;

  localparam int CYCLE_LIMIT   = 250000;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 10;
  localparam int PHASE_ITEMS   = 180;

  // Codes outside the defined set
  localparam logic [1:0]         SRC_NONE  = 2'd3;
  localparam logic [2:0]         STAT_RSV6 = 3'd6;
  localparam logic [2:0]         STAT_RSV7 = 3'd7;
  localparam logic [RegIdxW-1:0] REG_NONE  = 3'd7;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [RegIdxW-1:0] cfg_index;
  logic [CfgW-1:0]    cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic               action;
  logic [1:0]         source;
  logic [2:0]         status;
  logic               out_valid;
  logic               out_ready;
  logic               led_on;
  logic [2:0]         mode;

  int error_count;
  int in_flight;
  int cycles_run = 0;
  int items_sent = 0;
  bit idle_en    = 1'b1;
  bit hold_req   = 1'b0;

  always #2 clk = ~clk;

  always @(posedge clk) cycles_run++;

  alarm_led_pattern_controller u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .source(source), .status(status),
    .out_valid(out_valid), .out_ready(out_ready), .led_on(led_on), .mode(mode)
  );

  alp_checker u_chk (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .source(source), .status(status),
    .out_valid(out_valid), .out_ready(out_ready), .led_on(led_on), .mode(mode),
    .error_count(error_count), .in_flight(in_flight)
  );

  // Hang guard
  initial begin
    wait (cycles_run >= CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  // Result side: random stall bursts, plus a long hold-off on request
  initial begin : rx_proc
    out_ready <= 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 6) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one item, wait for acceptance; may leave a short gap afterwards
  task automatic send_item(input logic act, input logic [1:0] src, input logic [2:0] st);
    in_valid <= 1'b1;
    action   <= act;
    source   <= src;
    status   <= st;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
  endtask

  // Tick with random don't-care fields
  task automatic tick();
    send_item(ACT_TICK, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
  endtask

  task automatic set_status(input logic [1:0] src, input logic [2:0] st);
    send_item(ACT_SET, src, st);
  endtask

  // Drop valid and wait until every result is back
  task automatic settle();
    in_valid <= 1'b0;
    while (in_flight != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write all timing registers, then an index past the last one
  task automatic write_timing(input cfg_t c);
    logic [CfgW-1:0] vals [7];
    vals[0] = c.alarm_on_ms;  vals[1] = c.alarm_off_ms;
    vals[2] = c.conn_on_ms;   vals[3] = c.conn_off_ms;
    vals[4] = c.pulse_on_ms;  vals[5] = c.pulse_gap_ms;
    vals[6] = c.pause_ms;
    for (int i = 0; i <= 7; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= RegIdxW'(i);
      cfg_data  <= (RegIdxW'(i) == REG_NONE) ? CfgW'($urandom) : vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic cfg_t rand_timing(input int hi);
    cfg_t c;
    c.alarm_on_ms  = CfgW'($urandom_range(0, hi));
    c.alarm_off_ms = CfgW'($urandom_range(0, hi));
    c.conn_on_ms   = CfgW'($urandom_range(0, hi));
    c.conn_off_ms  = CfgW'($urandom_range(0, hi));
    c.pulse_on_ms  = CfgW'($urandom_range(0, hi));
    c.pulse_gap_ms = CfgW'($urandom_range(0, hi));
    c.pause_ms     = CfgW'($urandom_range(0, hi));
    return c;
  endfunction

  // Random traffic: mostly a status write followed by a run of ticks
  task automatic run_phase(input int budget, input bit with_hold);
    int stop_at;
    int hold_at;
    int kind;
    logic [1:0] src;
    logic [2:0] st;
    stop_at = items_sent + budget;
    hold_at = with_hold ? items_sent + $urandom_range(10, budget / 2) : stop_at + 1;
    while (items_sent < stop_at) begin
      if (items_sent >= hold_at) begin
        hold_req = 1'b1;
        hold_at  = stop_at + 1;
      end
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        src = 2'($urandom_range(SRC_ALARM, SRC_LOSS));
        if (src == SRC_LOSS)
          st = $urandom_range(0, 3) != 0 ? 3'($urandom_range(MODE_LOSS1, MODE_LOSS3))
                                          : 3'($urandom_range(MODE_IDLE, MODE_LOSS3));
        else
          st = $urandom_range(0, 1) != 0 ? MODE_IDLE : 3'($urandom_range(MODE_IDLE, MODE_LOSS3));
        set_status(src, st);
        repeat ($urandom_range(1, 30)) tick();
      end else if (kind < 9) begin
        // drop alarm and connection so link-loss bursts show
        set_status(SRC_CONN, MODE_IDLE);
        set_status(SRC_ALARM, MODE_IDLE);
        if ($urandom_range(0, 2) == 0) set_status(SRC_LOSS, MODE_IDLE);
        repeat ($urandom_range(1, 12)) tick();
      end else begin
        send_item(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
      end
    end
  endtask

  initial begin : stim
    cfg_t all_zero;
    cfg_t all_ones;
    all_zero = '0;
    all_ones = '1;
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    action    <= ACT_TICK;
    source    <= SRC_ALARM;
    status    <= MODE_IDLE;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: every mode, reserved codes, ignored source, mode change mid-burst
    send_item(ACT_TICK, SRC_NONE, STAT_RSV7);
    set_status(SRC_ALARM, MODE_ALARM);
    tick();
    set_status(SRC_CONN, MODE_CONN);
    tick();
    tick();
    set_status(SRC_NONE, STAT_RSV7);
    set_status(SRC_CONN, MODE_IDLE);
    set_status(SRC_ALARM, MODE_IDLE);
    set_status(SRC_LOSS, MODE_LOSS1);
    tick();
    tick();
    set_status(SRC_LOSS, MODE_LOSS3);
    tick();
    set_status(SRC_LOSS, STAT_RSV6);
    tick();
    set_status(SRC_LOSS, STAT_RSV7);
    tick();
    set_status(SRC_LOSS, MODE_ALARM);
    tick();
    set_status(SRC_LOSS, MODE_CONN);
    tick();
    set_status(SRC_LOSS, MODE_LOSS2);
    tick();
    set_status(SRC_LOSS, MODE_IDLE);

    // Random phases over several timing settings
    run_phase(PHASE_ITEMS, 1'b0);
    settle();
    write_timing(all_zero);
    run_phase(PHASE_ITEMS, 1'b0);
    settle();
    write_timing(all_ones);
    run_phase(PHASE_ITEMS, 1'b1);
    settle();
    for (int p = 0; p < 4; p++) begin
      write_timing(rand_timing(12));
      run_phase(PHASE_ITEMS, p == 1);
      settle();
    end
    // Last stretch runs without idling
    write_timing(rand_timing(30));
    idle_en = 1'b0;
    run_phase(PHASE_ITEMS, 1'b0);
    settle();

    if (error_count == 0 && in_flight == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// File: alarm_led_pattern_controller.f
rtl/alp_pkg.sv
rtl/alp_cfg.sv
rtl/alp_core.sv
rtl/alarm_led_pattern_controller.sv
bench/alp_checker.sv
bench/tb_alarm_led_pattern_controller.sv
